@@ rtl/core/frmt_pkg.sv @@
// ----------------------------------------------------------------------------
// frmt_pkg
// Shared types and constants for the range-maximum binary indexed tree.
// ----------------------------------------------------------------------------
package frmt_pkg;

  localparam int unsigned IDX_W      = 11;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned IN_TDATA_W = 56;  // 11 + 11 + 32 bits, padded to bytes
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [VAL_W-1:0] MOST_NEG     = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [IDX_W-1:0] ACT_LEN_RST  = IDX_W'(1024);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;           // latch an accepted input word
    logic acc_clr;        // running maximum back to the most negative value
    logic rd_stored;      // read stored value at the node index
    logic rd_tree_idx;    // read tree node at the node index
    logic rd_tree_child;  // read tree node at node index minus child step
    logic wr_stored;      // write the item value at the write position
    logic wr_tree;        // write the running maximum to the current node
    logic j_init;         // child step back to one
    logic j_shift;        // double the child step
    logic idx_add_lb;     // move to the next covering node
    logic idx_sub_lb;     // jump left over a whole tree node
    logic idx_dec;        // step one position left
    logic clr_step;       // clear one entry of both memories
    logic out_load;       // load the result word into the output register
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic is_query;
    logic wr_ok;
    logic q_err;
    logic node_over;
    logic j_lt_lb;
    logic hi_eq_lo;
    logic can_jump;
    logic clr_done;
    logic out_stall;
  } sts_t;

endpackage

@@ rtl/core/frmt_dp.sv @@
// ----------------------------------------------------------------------------
// frmt_dp
// Datapath: value and tree memories, index registers, running maximum and
// the output register.
// ----------------------------------------------------------------------------
module frmt_dp
  import frmt_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [IDX_W-1:0]   act_len_i,
  input  logic               opcode_i,
  input  logic [IDX_W-1:0]   first_index_i,
  input  logic [IDX_W-1:0]   second_index_i,
  input  logic [VAL_W-1:0]   value_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [VAL_W-1:0]   range_max_o,
  output logic               range_error_o
);

  localparam int unsigned AW = $clog2(DEPTH + 1);
  localparam int unsigned NW = AW + 1;
  localparam int unsigned PW = (NW > IDX_W) ? NW : IDX_W;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

  logic [VAL_W-1:0] sv_mem [DEPTH+1];
  logic [VAL_W-1:0] tr_mem [DEPTH+1];

  logic [VAL_W-1:0] sv_rdata_q, tr_rdata_q, rdata;
  logic             rd_pend_q, rsel_q;
  logic [VAL_W-1:0] acc_q, acc_merged;
  logic [PW-1:0]    idx_q, lo_q, j_q;
  logic             op_q;
  logic [VAL_W-1:0] val_q;
  logic [AW-1:0]    clr_q;
  logic             out_valid_q, err_q;
  logic [VAL_W-1:0] max_q;

  logic [PW-1:0]    in_a, in_b, lb_idx, child_idx, eff_len;
  logic             swap;
  logic             sv_we, tr_we, tr_re;
  logic [AW-1:0]    sv_waddr, tr_waddr, tr_raddr;
  logic [VAL_W-1:0] sv_wdata, tr_wdata;

  assign in_a    = PW'(first_index_i);
  assign in_b    = PW'(second_index_i);
  assign swap    = in_a > in_b;
  assign eff_len = (PW'(act_len_i) > DEPTH_P) ? DEPTH_P : PW'(act_len_i);

  assign lb_idx    = idx_q & (~idx_q + PW'(1));
  assign child_idx = idx_q - j_q;

  assign rdata      = rsel_q ? tr_rdata_q : sv_rdata_q;
  assign acc_merged = (rd_pend_q && ($signed(rdata) > $signed(acc_q))) ? rdata : acc_q;

  assign sts_o.is_query  = op_q;
  assign sts_o.wr_ok     = (lo_q != '0) && (lo_q <= eff_len);
  assign sts_o.q_err     = (lo_q == '0) || (idx_q > eff_len);
  assign sts_o.node_over = idx_q > DEPTH_P;
  assign sts_o.j_lt_lb   = j_q < lb_idx;
  assign sts_o.hi_eq_lo  = idx_q == lo_q;
  assign sts_o.can_jump  = (idx_q - lb_idx) >= lo_q;
  assign sts_o.clr_done  = clr_q == AW'(DEPTH);
  assign sts_o.out_stall = out_valid_q && !out_ready_i;

  // Memory ports. The clearing pass writes both memories at one address.
  assign sv_we    = cmd_i.wr_stored || cmd_i.clr_step;
  assign sv_waddr = cmd_i.clr_step ? clr_q : lo_q[AW-1:0];
  assign sv_wdata = cmd_i.clr_step ? MOST_NEG : val_q;
  assign tr_we    = cmd_i.wr_tree || cmd_i.clr_step;
  assign tr_waddr = cmd_i.clr_step ? clr_q : idx_q[AW-1:0];
  assign tr_wdata = cmd_i.clr_step ? MOST_NEG : acc_merged;
  assign tr_re    = cmd_i.rd_tree_idx || cmd_i.rd_tree_child;
  assign tr_raddr = cmd_i.rd_tree_child ? child_idx[AW-1:0] : idx_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (sv_we) begin
      sv_mem[sv_waddr] <= sv_wdata;
    end
    if (cmd_i.rd_stored) begin
      sv_rdata_q <= sv_mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tr_we) begin
      tr_mem[tr_waddr] <= tr_wdata;
    end
    if (tr_re) begin
      tr_rdata_q <= tr_mem[tr_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      rsel_q      <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd_stored || tr_re;
      rsel_q    <= tr_re;
      if (cmd_i.clr_step && !sts_o.clr_done) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      val_q <= value_i;
      if (opcode_i == OP_QUERY) begin
        lo_q  <= swap ? in_b : in_a;
        idx_q <= swap ? in_a : in_b;
      end else begin
        lo_q  <= in_a;
        idx_q <= in_a;
      end
    end else if (cmd_i.idx_add_lb) begin
      idx_q <= idx_q + lb_idx;
    end else if (cmd_i.idx_sub_lb) begin
      idx_q <= idx_q - lb_idx;
    end else if (cmd_i.idx_dec) begin
      idx_q <= idx_q - PW'(1);
    end

    if (cmd_i.j_init) begin
      j_q <= PW'(1);
    end else if (cmd_i.j_shift) begin
      j_q <= {j_q[PW-2:0], 1'b0};
    end

    acc_q <= cmd_i.acc_clr ? MOST_NEG : acc_merged;

    if (cmd_i.out_load) begin
      max_q <= sts_o.q_err ? '0 : acc_q;
      err_q <= sts_o.q_err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign range_max_o   = max_q;
  assign range_error_o = err_q;

endmodule

@@ rtl/core/frmt_ctrl.sv @@
// ----------------------------------------------------------------------------
// frmt_ctrl
// Sequencer for the clearing pass, the write update walk and the query walk.
// ----------------------------------------------------------------------------
module frmt_ctrl
  import frmt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_DECODE = 10'b00_0000_0100,
    S_WSTORE = 10'b00_0000_1000,
    S_WNODE  = 10'b00_0001_0000,
    S_WACC   = 10'b00_0010_0000,
    S_QINIT  = 10'b00_0100_0000,
    S_QLOOP  = 10'b00_1000_0000,
    S_QINNER = 10'b01_0000_0000,
    S_QOUT   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts_i.is_query) begin
          state_d = sts_i.wr_ok ? S_WSTORE : S_IDLE;
        end else begin
          state_d = sts_i.q_err ? S_QOUT : S_QINIT;
        end
      end
      S_WSTORE: begin
        cmd_o.wr_stored = 1'b1;
        state_d         = S_WNODE;
      end
      S_WNODE: begin
        if (sts_i.node_over) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_stored = 1'b1;
          cmd_o.acc_clr   = 1'b1;
          cmd_o.j_init    = 1'b1;
          state_d         = S_WACC;
        end
      end
      S_WACC: begin
        if (sts_i.j_lt_lb) begin
          cmd_o.rd_tree_child = 1'b1;
          cmd_o.j_shift       = 1'b1;
        end else begin
          cmd_o.wr_tree    = 1'b1;
          cmd_o.idx_add_lb = 1'b1;
          state_d          = S_WNODE;
        end
      end
      S_QINIT: begin
        cmd_o.rd_stored = 1'b1;
        cmd_o.acc_clr   = 1'b1;
        state_d         = S_QLOOP;
      end
      S_QLOOP: begin
        if (sts_i.hi_eq_lo) begin
          state_d = S_QOUT;
        end else begin
          cmd_o.idx_dec = 1'b1;
          state_d       = S_QINNER;
        end
      end
      S_QINNER: begin
        if (sts_i.can_jump) begin
          cmd_o.rd_tree_idx = 1'b1;
          cmd_o.idx_sub_lb  = 1'b1;
        end else begin
          cmd_o.rd_stored = 1'b1;
          state_d         = S_QLOOP;
        end
      end
      S_QOUT: begin
        if (!sts_i.out_stall) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/fenwick_range_max_tree.sv @@
// ----------------------------------------------------------------------------
// fenwick_range_max_tree
// Range-maximum binary indexed tree over signed 32-bit values.
// ----------------------------------------------------------------------------
// Steps: a write decodes, stores the value, then for every covering node up to
//   DEPTH reads the node's stored value and each child node and writes the node.
//   A write to a bad position ends after its decode step.
// A query decodes, reads the stored value at the right bound, then steps left by
//   single positions and tree-node jumps, and waits while the previous result word
//   is still pending downstream. A query with a bad bound skips the walk.
// Throughput: one word at a time; the next word is taken once the walk ends.
// Reset: a clearing pass writes the most negative value into every entry of
//   both memories; no input word is taken until it finishes.
// ----------------------------------------------------------------------------
//
// Each word carries an opcode in tuser. A write stores the value at a position
// and rebuilds every tree node that covers it from the node's own stored value
// and its child nodes. A query walks from the right bound down to the left
// bound, taking whole tree nodes where they lie inside the range and single
// stored values otherwise. Swapped bounds are exchanged on the way in, and a
// bound of zero or beyond the active length returns range_error with a zero
// maximum. A result word waits in an output register, so the block can take
// the next input word while a result is still pending downstream.
//
// The active length register is written through its own valid/ready channel,
// which is always ready. Values above DEPTH behave as DEPTH.
module fenwick_range_max_tree
  import frmt_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input words.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: first_index[10:0], second_index[21:11], value[53:22], zero pad [55:54]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: opcode (0 write, 1 query)
  input  logic                   s_axis_tuser,
  // Result words.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: range_max[31:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: range_error
  output logic                   m_axis_tuser,
  // Active length register write channel.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [IDX_W-1:0]       cfg_data_i
);

  logic [IDX_W-1:0] act_len_q;
  cmd_t             cmd;
  sts_t             sts;

  // The register may be written at any time the channel is valid; the user
  // only does so while the block is idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_len_q <= ACT_LEN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      act_len_q <= cfg_data_i;
    end
  end

  frmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  frmt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .act_len_i      (act_len_q),
    .opcode_i       (s_axis_tuser),
    .first_index_i  (s_axis_tdata[IDX_W-1:0]),
    .second_index_i (s_axis_tdata[2*IDX_W-1:IDX_W]),
    .value_i        (s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .range_max_o    (m_axis_tdata),
    .range_error_o  (m_axis_tuser)
  );

endmodule
